### sv/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types, constants and character helpers for the JSON syntax
// validator: parse states, verdict codes, nesting kinds and stack sizing.
// ----------------------------------------------------------------------------
package jsv_pkg;

	// nesting stack and offset counter sizing
	localparam int MAX_DEPTH   = 64;
	localparam int OFFSET_BITS = 24;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W      = $clog2(MAX_DEPTH);

	// result offset field is fixed at 24 bits
	localparam int OFF_OUT_W = 24;
	localparam int CMP_W     = (OFFSET_BITS > OFF_OUT_W) ? OFFSET_BITS : OFF_OUT_W;
	localparam logic [OFF_OUT_W-1:0] OFF_MAX = '1;

	// verdict codes
	localparam logic [1:0] VERDICT_RUN    = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	// nesting kinds
	localparam logic KIND_OBJ = 1'b0;
	localparam logic KIND_ARR = 1'b1;

	// escape counter
	localparam logic [2:0] HEX_DIGITS = 3'd4;

	// characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_L  = 8'h6C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_S  = 8'h73;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	typedef enum logic [4:0] {
		ST_INIT         = 5'd0,
		ST_OBJ_EMPTY    = 5'd1,
		ST_OBJ_KEY      = 5'd2,
		ST_NAME         = 5'd3,
		ST_NAME_ESC     = 5'd4,
		ST_NAME_HEX     = 5'd5,
		ST_COLON        = 5'd6,
		ST_VALUE        = 5'd7,
		ST_ARR_EMPTY    = 5'd8,
		ST_STR          = 5'd9,
		ST_STR_ESC      = 5'd10,
		ST_STR_HEX      = 5'd11,
		ST_AFTER        = 5'd12,
		ST_FINISH       = 5'd13,
		ST_LIT_TRUE     = 5'd14,
		ST_LIT_FALSE    = 5'd15,
		ST_LIT_NULL     = 5'd16,
		ST_NUM_MINUS    = 5'd17,
		ST_NUM_ZERO     = 5'd18,
		ST_NUM_INT      = 5'd19,
		ST_NUM_DOT      = 5'd20,
		ST_NUM_FRAC     = 5'd21,
		ST_NUM_EXP      = 5'd22,
		ST_NUM_EXP_SIGN = 5'd23,
		ST_NUM_EXP_DIG  = 5'd24
	} parse_state_t;

	// effect of one byte on the parser and the nesting stack
	typedef struct packed {
		parse_state_t st;
		logic         fail;
		logic         push;
		logic         pop;
		logic         kind;
	} act_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]           verdict;
		logic [OFF_OUT_W-1:0] error_offset;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic ends_number(input logic [7:0] c);
		return is_ws(c) || (c inside {CH_COMMA, CH_RBRACE, CH_RBRACK});
	endfunction

	function automatic logic is_simple_escape(input logic [7:0] c);
		return c inside {CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_T,
			CH_LOW_N, CH_LOW_R, CH_QUOTE};
	endfunction

	// length of the literal matched in a literal state
	function automatic logic [2:0] lit_len(input parse_state_t s);
		logic [2:0] len;
		case (s)
			ST_LIT_FALSE: len = 3'd5;
			default:      len = 3'd4;
		endcase
		return len;
	endfunction

	// expected character at a position of a literal
	function automatic logic [7:0] lit_char(input parse_state_t s, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (s)
			ST_LIT_TRUE: begin
				case (pos)
					3'd0:    ch = CH_LOW_T;
					3'd1:    ch = CH_LOW_R;
					3'd2:    ch = CH_LOW_U;
					3'd3:    ch = CH_LOW_E;
					default: ch = 8'h00;
				endcase
			end
			ST_LIT_FALSE: begin
				case (pos)
					3'd0:    ch = CH_LOW_F;
					3'd1:    ch = CH_LOW_A;
					3'd2:    ch = CH_LOW_L;
					3'd3:    ch = CH_LOW_S;
					3'd4:    ch = CH_LOW_E;
					default: ch = 8'h00;
				endcase
			end
			ST_LIT_NULL: begin
				case (pos)
					3'd0:    ch = CH_LOW_N;
					3'd1:    ch = CH_LOW_U;
					3'd2:    ch = CH_LOW_L;
					3'd3:    ch = CH_LOW_L;
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### sv/jsv_text_if.sv
// ----------------------------------------------------------------------------
// jsv_text_if
// Byte channel into the validator: one character and a last-byte flag per
// transaction.
// ----------------------------------------------------------------------------
interface jsv_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/jsv_status_if.sv
// ----------------------------------------------------------------------------
// jsv_status_if
// Verdict channel out of the validator: verdict code and first error offset
// per transaction.
// ----------------------------------------------------------------------------
interface jsv_status_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     verdict;
	logic [jsv_pkg::OFF_OUT_W-1:0]  error_offset;

	modport source (output valid, output verdict, output error_offset, input ready);
	modport sink (input valid, input verdict, input error_offset, output ready);
endinterface

### sv/json_syntax_validator_core.sv
// ----------------------------------------------------------------------------
// json_syntax_validator_core
// Streaming JSON syntax checker with a bounded object/array nesting stack.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while text.ready is high and
// returns one verdict per byte (running, accepted on the last byte, or
// rejected with the offset of the first error). The byte is parsed in the
// cycle it is accepted, so the rate is set by the parser update and the
// nesting stack access. The stack lives in a 1-bit synchronous RAM of
// MAX_DEPTH entries: the top entry is held in a register and the entry
// below it is prefetched every cycle, with a forward path for the entry
// written by a push in the cycle before. Verdicts leave through a two-entry
// output buffer, so text.ready drops only when two verdicts wait unread.
// The stack needs no clearing after reset: only entries below the current
// depth are ever used.
// ----------------------------------------------------------------------------
module json_syntax_validator_core (
	input  logic                clk,
	input  logic                arst_n,
	jsv_text_if.sink            text,
	jsv_status_if.source        status
);

	import jsv_pkg::*;

	// parser state
	parse_state_t         state_q;
	logic [2:0]           lit_q;
	logic [2:0]           esc_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic                 top_q;
	logic                 err_q;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic                 fwd_q;
	logic                 fwd_bit_q;

	// output buffer
	logic                 out_valid_q;
	res_t                 out_q;
	logic                 skid_valid_q;
	res_t                 skid_q;

	logic                 in_fire;
	logic                 out_fire;
	logic [7:0]           c;
	logic                 last;

	logic                 open_ok;
	logic                 below;
	logic                 ram_rdata;
	logic                 ram_we;
	logic [DEPTH_W-1:0]   depth_dec;
	logic [DEPTH_W-1:0]   depth_n;
	logic [DEPTH_W-1:0]   raddr_full;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;

	act_t                 op_obj;
	act_t                 op_arr;
	act_t                 cl_obj;
	act_t                 cl_arr;
	act_t                 vs;
	act_t                 av;
	act_t                 act;
	logic [2:0]           lit_n;
	logic [2:0]           esc_n;
	logic [2:0]           lit_inc;
	logic [2:0]           esc_inc;

	logic                 step_fail;
	logic                 err_n;
	logic                 do_push;
	logic                 do_pop;

	logic [CMP_W-1:0]     cnt_ext;
	logic [OFF_OUT_W-1:0] off_sat;
	res_t                 res;

	// handshakes
	assign c         = text.data_byte;
	assign last      = text.last_byte;
	assign text.ready = !skid_valid_q;
	assign in_fire   = text.valid && !skid_valid_q;
	assign out_fire  = out_valid_q && status.ready;

	// stack helpers
	assign open_ok   = depth_q < DEPTH_W'(MAX_DEPTH);
	assign below     = fwd_q ? fwd_bit_q : ram_rdata;
	assign depth_dec = depth_q - DEPTH_W'(1);

	// open and close actions
	always_comb begin
		op_obj = '{st: ST_OBJ_EMPTY, fail: !open_ok, push: 1'b1, pop: 1'b0, kind: KIND_OBJ};
		op_arr = '{st: ST_ARR_EMPTY, fail: !open_ok, push: 1'b1, pop: 1'b0, kind: KIND_ARR};
		cl_obj = '{st: (depth_q == DEPTH_W'(1)) ? ST_FINISH : ST_AFTER,
			fail: (depth_q == '0) || (top_q != KIND_OBJ), push: 1'b0, pop: 1'b1,
			kind: KIND_OBJ};
		cl_arr = '{st: (depth_q == DEPTH_W'(1)) ? ST_FINISH : ST_AFTER,
			fail: (depth_q == '0) || (top_q != KIND_ARR), push: 1'b0, pop: 1'b1,
			kind: KIND_ARR};
	end

	// start of a value
	always_comb begin
		vs = '{st: state_q, fail: 1'b0, push: 1'b0, pop: 1'b0, kind: KIND_OBJ};
		if (c == CH_QUOTE) begin
			vs.st = ST_STR;
		end else if (c == CH_MINUS) begin
			vs.st = ST_NUM_MINUS;
		end else if (c == CH_ZERO) begin
			vs.st = ST_NUM_ZERO;
		end else if (c inside {[CH_ONE:CH_NINE]}) begin
			vs.st = ST_NUM_INT;
		end else if (c == CH_LOW_T) begin
			vs.st = ST_LIT_TRUE;
		end else if (c == CH_LOW_F) begin
			vs.st = ST_LIT_FALSE;
		end else if (c == CH_LOW_N) begin
			vs.st = ST_LIT_NULL;
		end else if (c == CH_LBRACE) begin
			vs = op_obj;
		end else if (c == CH_LBRACK) begin
			vs = op_arr;
		end else begin
			vs.fail = 1'b1;
		end
	end

	// byte following a complete value
	always_comb begin
		av = '{st: ST_AFTER, fail: 1'b0, push: 1'b0, pop: 1'b0, kind: KIND_OBJ};
		if (is_ws(c)) begin
			av.st = ST_AFTER;
		end else if (c == CH_COMMA) begin
			if (depth_q == '0) begin
				av.fail = 1'b1;
			end else begin
				av.st = (top_q == KIND_ARR) ? ST_VALUE : ST_OBJ_KEY;
			end
		end else if (c == CH_RBRACK) begin
			av = cl_arr;
		end else if (c == CH_RBRACE) begin
			av = cl_obj;
		end else begin
			av.fail = 1'b1;
		end
	end

	assign lit_inc = lit_q + 3'd1;
	assign esc_inc = esc_q + 3'd1;

	// next state of the parser
	always_comb begin
		act   = '{st: state_q, fail: 1'b0, push: 1'b0, pop: 1'b0, kind: KIND_OBJ};
		lit_n = lit_q;
		esc_n = esc_q;
		case (state_q)
			ST_INIT: begin
				if (!is_ws(c)) begin
					if (c == CH_LBRACE) act = op_obj;
					else if (c == CH_LBRACK) act = op_arr;
					else act.fail = 1'b1;
				end
			end
			ST_OBJ_EMPTY: begin
				if (!is_ws(c)) begin
					if (c == CH_QUOTE) act.st = ST_NAME;
					else if (c == CH_RBRACE) act = cl_obj;
					else act.fail = 1'b1;
				end
			end
			ST_OBJ_KEY: begin
				if (!is_ws(c)) begin
					if (c == CH_QUOTE) act.st = ST_NAME;
					else act.fail = 1'b1;
				end
			end
			ST_NAME, ST_STR: begin
				if (c == CH_BSLASH) begin
					act.st = (state_q == ST_NAME) ? ST_NAME_ESC : ST_STR_ESC;
				end else if (c == CH_QUOTE) begin
					act.st = (state_q == ST_NAME) ? ST_COLON : ST_AFTER;
				end
			end
			ST_NAME_ESC, ST_STR_ESC: begin
				if (is_simple_escape(c)) begin
					act.st = (state_q == ST_NAME_ESC) ? ST_NAME : ST_STR;
				end else if (c == CH_LOW_U) begin
					esc_n  = '0;
					act.st = (state_q == ST_NAME_ESC) ? ST_NAME_HEX : ST_STR_HEX;
				end else begin
					act.fail = 1'b1;
				end
			end
			ST_NAME_HEX, ST_STR_HEX: begin
				esc_n = esc_inc;
				if (esc_inc >= HEX_DIGITS) begin
					esc_n  = '0;
					act.st = (state_q == ST_NAME_HEX) ? ST_NAME : ST_STR;
				end
			end
			ST_COLON: begin
				if (!is_ws(c)) begin
					if (c == CH_COLON) act.st = ST_VALUE;
					else act.fail = 1'b1;
				end
			end
			ST_VALUE: begin
				if (!is_ws(c)) begin
					act   = vs;
					lit_n = 3'd1;
				end
			end
			ST_ARR_EMPTY: begin
				if (!is_ws(c)) begin
					if (c == CH_RBRACK) begin
						act = cl_arr;
					end else begin
						act   = vs;
						lit_n = 3'd1;
					end
				end
			end
			ST_AFTER: act = av;
			ST_FINISH: begin
				if (!is_ws(c)) act.fail = 1'b1;
			end
			ST_LIT_TRUE, ST_LIT_FALSE, ST_LIT_NULL: begin
				if (lit_q >= lit_len(state_q) || c != lit_char(state_q, lit_q)) begin
					act.fail = 1'b1;
				end else if (lit_inc == lit_len(state_q)) begin
					lit_n  = '0;
					act.st = ST_AFTER;
				end else begin
					lit_n = lit_inc;
				end
			end
			ST_NUM_MINUS: begin
				if (c == CH_ZERO) act.st = ST_NUM_ZERO;
				else if (is_digit(c)) act.st = ST_NUM_INT;
				else act.fail = 1'b1;
			end
			ST_NUM_ZERO, ST_NUM_INT: begin
				if (is_digit(c) && state_q == ST_NUM_INT) act.st = ST_NUM_INT;
				else if (c == CH_DOT) act.st = ST_NUM_DOT;
				else if (c == CH_LOW_E || c == CH_UP_E) act.st = ST_NUM_EXP;
				else if (ends_number(c)) act = av;
				else act.fail = 1'b1;
			end
			ST_NUM_DOT: begin
				if (is_digit(c)) act.st = ST_NUM_FRAC;
				else act.fail = 1'b1;
			end
			ST_NUM_FRAC: begin
				if (is_digit(c)) act.st = ST_NUM_FRAC;
				else if (c == CH_LOW_E || c == CH_UP_E) act.st = ST_NUM_EXP;
				else if (ends_number(c)) act = av;
				else act.fail = 1'b1;
			end
			ST_NUM_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) act.st = ST_NUM_EXP_SIGN;
				else if (is_digit(c)) act.st = ST_NUM_EXP_DIG;
				else act.fail = 1'b1;
			end
			ST_NUM_EXP_SIGN: begin
				if (is_digit(c)) act.st = ST_NUM_EXP_DIG;
				else act.fail = 1'b1;
			end
			ST_NUM_EXP_DIG: begin
				if (is_digit(c)) act.st = ST_NUM_EXP_DIG;
				else if (ends_number(c)) act = av;
				else act.fail = 1'b1;
			end
			default: act.fail = 1'b1;
		endcase
	end

	// error and stack control for the accepted byte
	assign step_fail = !err_q && act.fail;
	assign err_n     = err_q || step_fail;
	assign do_push   = in_fire && !err_q && !act.fail && act.push;
	assign do_pop    = in_fire && !err_q && !act.fail && act.pop;

	always_comb begin
		if (in_fire && last) depth_n = '0;
		else if (do_push) depth_n = depth_q + DEPTH_W'(1);
		else if (do_pop) depth_n = depth_dec;
		else depth_n = depth_q;
	end

	// old top spills to the ram on a push; prefetch the entry under the next top
	assign ram_we     = do_push && (depth_q != '0);
	assign waddr      = depth_dec[ADDR_W-1:0];
	assign raddr_full = depth_n - DEPTH_W'(2);
	assign raddr      = raddr_full[ADDR_W-1:0];

	jsv_ram #(
		.WIDTH (1),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (top_q),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// verdict for the accepted byte
	assign cnt_ext = CMP_W'(cnt_q);
	assign off_sat = (cnt_ext > CMP_W'(OFF_MAX)) ? OFF_MAX : cnt_ext[OFF_OUT_W-1:0];

	always_comb begin
		if (last) begin
			if (!err_n && act.st == ST_FINISH) begin
				res = '{verdict: VERDICT_ACCEPT, error_offset: '0};
			end else begin
				res = '{verdict: VERDICT_REJECT, error_offset: off_sat};
			end
		end else if (err_n) begin
			res = '{verdict: VERDICT_REJECT, error_offset: off_sat};
		end else begin
			res = '{verdict: VERDICT_RUN, error_offset: '0};
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			lit_q     <= '0;
			esc_q     <= '0;
			depth_q   <= '0;
			top_q     <= KIND_OBJ;
			err_q     <= 1'b0;
			cnt_q     <= '0;
			fwd_q     <= 1'b0;
			fwd_bit_q <= 1'b0;
		end else begin
			fwd_q     <= ram_we;
			fwd_bit_q <= top_q;
			depth_q   <= depth_n;
			if (in_fire) begin
				if (last) begin
					state_q <= ST_INIT;
					lit_q   <= '0;
					esc_q   <= '0;
					err_q   <= 1'b0;
					cnt_q   <= '0;
				end else if (!err_q) begin
					err_q <= err_n;
					if (!act.fail) begin
						state_q <= act.st;
						lit_q   <= lit_n;
						esc_q   <= esc_n;
						if (cnt_q != '1) cnt_q <= cnt_q + OFFSET_BITS'(1);
					end
					if (do_push) top_q <= act.kind;
					else if (do_pop) top_q <= below;
				end
			end
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_fire;
				end
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_fire) out_q <= res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign status.valid        = out_valid_q;
	assign status.verdict      = out_q.verdict;
	assign status.error_offset = out_q.error_offset;

endmodule

### sv/jsv_ram.sv
// ----------------------------------------------------------------------------
// jsv_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module jsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### tb/jsv_verdict_checker.sv
// ----------------------------------------------------------------------------
// jsv_verdict_checker
// Watches the byte and verdict channels of the JSON syntax validator, runs
// its own parser on every accepted byte and compares each verdict
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module jsv_verdict_checker (
	input  logic  clk,
	input  logic  arst_n,
	jsv_text_if   text,
	jsv_status_if status,
	output int    fail_count,
	output int    open_count,
	output int    verdicts_seen,
	output int    docs_ok,
	output int    docs_bad
);

	import jsv_pkg::*;

	localparam longint unsigned OFFSET_TOP = (64'd1 << OFFSET_BITS) - 64'd1;

	// parser copy
	parse_state_t    pstate;
	logic [2:0]      word_pos;
	logic [2:0]      hex_cnt;
	logic            level_kind [MAX_DEPTH];
	int unsigned     level_count;
	longint unsigned byte_offset;
	logic            syntax_bad;

	// predicted verdicts in arrival order
	res_t pending_verdicts [$];
	res_t want;
	res_t got;
	int   mismatches = 0;
	int   seen = 0;
	int   n_ok = 0;
	int   n_bad = 0;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_parser();
		pstate      = ST_INIT;
		word_pos    = 3'd0;
		hex_cnt     = 3'd0;
		level_count = 0;
		byte_offset = 0;
		syntax_bad  = 1'b0;
	endfunction

	// open a nesting level, rejecting past the stack limit
	function automatic void push_level(input logic kind);
		if (level_count >= MAX_DEPTH) begin
			syntax_bad = 1'b1;
		end else begin
			level_kind[level_count] = kind;
			level_count++;
			pstate = (kind == KIND_ARR) ? ST_ARR_EMPTY : ST_OBJ_EMPTY;
		end
	endfunction

	// close a level; the closer must match the innermost opener
	function automatic void pop_level(input logic kind);
		if (level_count == 0 || level_kind[level_count-1] != kind) begin
			syntax_bad = 1'b1;
		end else begin
			level_count--;
			pstate = (level_count == 0) ? ST_FINISH : ST_AFTER;
		end
	endfunction

	// first byte of a value
	function automatic void start_value(input logic [7:0] c);
		word_pos = 3'd1;
		if (c == CH_QUOTE) pstate = ST_STR;
		else if (c == CH_MINUS) pstate = ST_NUM_MINUS;
		else if (c == CH_ZERO) pstate = ST_NUM_ZERO;
		else if (is_numeral(c)) pstate = ST_NUM_INT;
		else if (c == CH_LOW_T) pstate = ST_LIT_TRUE;
		else if (c == CH_LOW_F) pstate = ST_LIT_FALSE;
		else if (c == CH_LOW_N) pstate = ST_LIT_NULL;
		else if (c == CH_LBRACE) push_level(KIND_OBJ);
		else if (c == CH_LBRACK) push_level(KIND_ARR);
		else syntax_bad = 1'b1;
	endfunction

	// separator or closer after a complete value
	function automatic void after_value(input logic [7:0] c);
		pstate = ST_AFTER;
		if (!is_blank(c)) begin
			if (c == CH_COMMA) begin
				if (level_count == 0)
					syntax_bad = 1'b1;
				else
					pstate = (level_kind[level_count-1] == KIND_ARR) ? ST_VALUE : ST_OBJ_KEY;
			end else if (c == CH_RBRACK) begin
				pop_level(KIND_ARR);
			end else if (c == CH_RBRACE) begin
				pop_level(KIND_OBJ);
			end else begin
				syntax_bad = 1'b1;
			end
		end
	endfunction

	// byte that may end a number; the ending byte is parsed as the next token
	function automatic void close_number(input logic [7:0] c, input logic exp_ok);
		if (exp_ok && (c == CH_LOW_E || c == CH_UP_E))
			pstate = ST_NUM_EXP;
		else if (is_blank(c) || c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK)
			after_value(c);
		else
			syntax_bad = 1'b1;
	endfunction

	// true, false or null, one character at a time
	function automatic void take_word(input logic [7:0] c);
		string word;
		case (pstate)
			ST_LIT_TRUE:  word = "true";
			ST_LIT_FALSE: word = "false";
			default:      word = "null";
		endcase
		if (word_pos >= word.len() || c != word[word_pos]) begin
			syntax_bad = 1'b1;
		end else begin
			word_pos = word_pos + 3'd1;
			if (word_pos == word.len()) begin
				word_pos = 3'd0;
				pstate   = ST_AFTER;
			end
		end
	endfunction

	// byte after a backslash
	function automatic void take_escape(input logic [7:0] c, input parse_state_t back,
		input parse_state_t hex);
		case (c)
			CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_T, CH_LOW_N, CH_LOW_R, CH_QUOTE:
				pstate = back;
			CH_LOW_U: begin
				hex_cnt = 3'd0;
				pstate  = hex;
			end
			default: syntax_bad = 1'b1;
		endcase
	endfunction

	// four raw bytes after \u, not checked for hex
	function automatic void take_hex(input parse_state_t back);
		hex_cnt = hex_cnt + 3'd1;
		if (hex_cnt >= HEX_DIGITS) begin
			hex_cnt = 3'd0;
			pstate  = back;
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		case (pstate)
			ST_INIT: begin
				if (!is_blank(c)) begin
					if (c == CH_LBRACE) push_level(KIND_OBJ);
					else if (c == CH_LBRACK) push_level(KIND_ARR);
					else syntax_bad = 1'b1;
				end
			end
			ST_OBJ_EMPTY: begin
				if (!is_blank(c)) begin
					if (c == CH_QUOTE) pstate = ST_NAME;
					else if (c == CH_RBRACE) pop_level(KIND_OBJ);
					else syntax_bad = 1'b1;
				end
			end
			ST_OBJ_KEY: begin
				if (!is_blank(c)) begin
					if (c == CH_QUOTE) pstate = ST_NAME;
					else syntax_bad = 1'b1;
				end
			end
			ST_NAME: begin
				if (c == CH_BSLASH) pstate = ST_NAME_ESC;
				else if (c == CH_QUOTE) pstate = ST_COLON;
			end
			ST_NAME_ESC: take_escape(c, ST_NAME, ST_NAME_HEX);
			ST_NAME_HEX: take_hex(ST_NAME);
			ST_COLON: begin
				if (!is_blank(c)) begin
					if (c == CH_COLON) pstate = ST_VALUE;
					else syntax_bad = 1'b1;
				end
			end
			ST_VALUE: begin
				if (!is_blank(c)) start_value(c);
			end
			ST_ARR_EMPTY: begin
				if (!is_blank(c)) begin
					if (c == CH_RBRACK) pop_level(KIND_ARR);
					else start_value(c);
				end
			end
			ST_STR: begin
				if (c == CH_BSLASH) pstate = ST_STR_ESC;
				else if (c == CH_QUOTE) pstate = ST_AFTER;
			end
			ST_STR_ESC: take_escape(c, ST_STR, ST_STR_HEX);
			ST_STR_HEX: take_hex(ST_STR);
			ST_AFTER:   after_value(c);
			ST_FINISH: begin
				if (!is_blank(c)) syntax_bad = 1'b1;
			end
			ST_LIT_TRUE, ST_LIT_FALSE, ST_LIT_NULL: take_word(c);
			ST_NUM_MINUS: begin
				if (c == CH_ZERO) pstate = ST_NUM_ZERO;
				else if (is_numeral(c)) pstate = ST_NUM_INT;
				else syntax_bad = 1'b1;
			end
			ST_NUM_ZERO, ST_NUM_INT: begin
				// a digit after a leading zero is not a number end, so it rejects
				if (!(is_numeral(c) && pstate == ST_NUM_INT)) begin
					if (c == CH_DOT) pstate = ST_NUM_DOT;
					else close_number(c, 1'b1);
				end
			end
			ST_NUM_DOT: begin
				if (is_numeral(c)) pstate = ST_NUM_FRAC;
				else syntax_bad = 1'b1;
			end
			ST_NUM_FRAC: begin
				if (!is_numeral(c)) close_number(c, 1'b1);
			end
			ST_NUM_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) pstate = ST_NUM_EXP_SIGN;
				else if (is_numeral(c)) pstate = ST_NUM_EXP_DIG;
				else syntax_bad = 1'b1;
			end
			ST_NUM_EXP_SIGN: begin
				if (is_numeral(c)) pstate = ST_NUM_EXP_DIG;
				else syntax_bad = 1'b1;
			end
			ST_NUM_EXP_DIG: begin
				if (!is_numeral(c)) close_number(c, 1'b0);
			end
			default: syntax_bad = 1'b1;
		endcase
	endfunction

	function automatic logic [OFF_OUT_W-1:0] capped_offset();
		return (byte_offset > OFF_MAX) ? OFF_MAX : OFF_OUT_W'(byte_offset);
	endfunction

	// verdict for one byte; the parser restarts after the last byte
	function automatic res_t predict_verdict(input logic [7:0] c, input logic lst);
		res_t r;
		if (!syntax_bad) parse_char(c);
		r.verdict      = VERDICT_RUN;
		r.error_offset = '0;
		if (lst) begin
			if (!syntax_bad && pstate == ST_FINISH) begin
				r.verdict = VERDICT_ACCEPT;
			end else begin
				r.verdict      = VERDICT_REJECT;
				r.error_offset = capped_offset();
			end
			clear_parser();
		end else if (syntax_bad) begin
			r.verdict      = VERDICT_REJECT;
			r.error_offset = capped_offset();
		end else if (byte_offset < OFFSET_TOP) begin
			byte_offset++;
		end
		return r;
	endfunction

	// predict on byte transactions, compare on verdict transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			pending_verdicts.delete();
			fail_count    <= 0;
			open_count    <= 0;
			verdicts_seen <= 0;
			docs_ok       <= 0;
			docs_bad      <= 0;
		end else begin
			if (text.valid && text.ready) begin
				want = predict_verdict(text.data_byte, text.last_byte);
				pending_verdicts.push_back(want);
				if (text.last_byte) begin
					if (want.verdict == VERDICT_ACCEPT) n_ok++;
					else n_bad++;
				end
			end
			if (status.valid && status.ready) begin
				got.verdict      = status.verdict;
				got.error_offset = status.error_offset;
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: verdict transaction with none expected: verdict %0d offset %0d",
						$time, got.verdict, got.error_offset);
				end else begin
					want = pending_verdicts.pop_front();
					seen++;
					if (got.verdict !== want.verdict) begin
						mismatches++;
						$display("%0t: verdict mismatch: expected %0d, actual %0d",
							$time, want.verdict, got.verdict);
					end
					if (got.error_offset !== want.error_offset) begin
						mismatches++;
						$display("%0t: error_offset mismatch: expected %0d, actual %0d",
							$time, want.error_offset, got.error_offset);
					end
				end
			end
			fail_count    <= mismatches;
			open_count    <= pending_verdicts.size();
			verdicts_seen <= seen;
			docs_ok       <= n_ok;
			docs_bad      <= n_bad;
		end
	end

endmodule

### tb/tb_json_syntax_validator_core.sv
// ----------------------------------------------------------------------------
// tb_json_syntax_validator_core
// Streams JSON documents into the validator: a few hand-picked documents,
// the nesting limit, then random well-formed, damaged and noise documents,
// with random gaps on both channels and one long verdict back-pressure.
// ----------------------------------------------------------------------------
module tb_json_syntax_validator_core;
	import jsv_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int CALM_AFTER   = 650;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 80;
	localparam int HOLD_AT      = 120;

	logic clk = 1'b0;
	logic arst_n;

	jsv_text_if   text_ch ();
	jsv_status_if status_ch ();

	int fail_count;
	int open_count;
	int verdicts_seen;
	int docs_ok;
	int docs_bad;

	// document under construction
	logic [7:0] doc [$];
	int         bytes_sent = 0;
	int         docs_sent = 0;
	int         quiet_cycles = 0;
	bit         long_hold_done = 1'b0;
	bit         stall_mode = 1'b1;

	// ws before, lone zero; raw bytes after \u; leading zero; wrong closer;
	// text after the outer closer; document cut short
	string directed_docs [6] = '{" [0]", "[\"\\u\\\"{]\"]", "[01]", "[1,}", "{}x", "["};

	json_syntax_validator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.status (status_ch)
	);

	jsv_verdict_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.text          (text_ch),
		.status        (status_ch),
		.fail_count    (fail_count),
		.open_count    (open_count),
		.verdicts_seen (verdicts_seen),
		.docs_ok       (docs_ok),
		.docs_bad      (docs_bad)
	);

	always #2 clk = ~clk;

	function automatic void load_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) doc.push_back(s[i]);
	endfunction

	function automatic void add_ws();
		logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) doc.push_back(blanks[$urandom_range(0, 5)]);
	endfunction

	function automatic void add_digit();
		doc.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	// string with plain bytes, simple escapes and \u with four raw bytes
	function automatic void add_string();
		logic [7:0] escapes [8] = '{CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_T,
			CH_LOW_N, CH_LOW_R, CH_QUOTE};
		logic [7:0] plain;
		doc.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 7))
				0: begin
					doc.push_back(CH_BSLASH);
					doc.push_back(escapes[$urandom_range(0, 7)]);
				end
				1: begin
					doc.push_back(CH_BSLASH);
					doc.push_back(CH_LOW_U);
					repeat (4) doc.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					plain = 8'($urandom_range(0, 255));
					if (plain == CH_QUOTE || plain == CH_BSLASH) plain = CH_LOW_A;
					doc.push_back(plain);
				end
			endcase
		end
		doc.push_back(CH_QUOTE);
	endfunction

	function automatic void add_number();
		if ($urandom_range(0, 2) == 0) doc.push_back(CH_MINUS);
		if ($urandom_range(0, 3) == 0) begin
			doc.push_back(CH_ZERO);
		end else begin
			doc.push_back(8'(CH_ONE + $urandom_range(0, 8)));
			repeat ($urandom_range(0, 3)) add_digit();
		end
		if ($urandom_range(0, 2) == 0) begin
			doc.push_back(CH_DOT);
			repeat ($urandom_range(1, 3)) add_digit();
		end
		if ($urandom_range(0, 3) == 0) begin
			doc.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
			case ($urandom_range(0, 2))
				1: doc.push_back(CH_PLUS);
				2: doc.push_back(CH_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(1, 2)) add_digit();
		end
	endfunction

	function automatic void add_scalar();
		case ($urandom_range(0, 4))
			0, 1: add_number();
			2: add_string();
			3: load_text("true");
			default: begin
				if ($urandom_range(0, 1) == 1) load_text("false");
				else load_text("null");
			end
		endcase
	endfunction

	function automatic logic [7:0] opener(input logic kind);
		return (kind == KIND_ARR) ? CH_LBRACK : CH_LBRACE;
	endfunction

	function automatic logic [7:0] closer(input logic kind);
		return (kind == KIND_ARR) ? CH_RBRACK : CH_RBRACE;
	endfunction

	// well-formed document, built level by level without recursion
	function automatic void add_tree();
		logic kinds [6];
		int   filled [6];
		int   lvl;
		int   depth_cap;
		depth_cap = $urandom_range(1, 5);
		add_ws();
		lvl       = 0;
		kinds[0]  = 1'($urandom_range(0, 1));
		filled[0] = 0;
		doc.push_back(opener(kinds[0]));
		while (lvl >= 0) begin
			if (filled[lvl] >= $urandom_range(0, 4) || doc.size() > 48) begin
				add_ws();
				doc.push_back(closer(kinds[lvl]));
				lvl--;
			end else begin
				if (filled[lvl] != 0) begin
					add_ws();
					doc.push_back(CH_COMMA);
				end
				add_ws();
				if (kinds[lvl] == KIND_OBJ) begin
					add_string();
					add_ws();
					doc.push_back(CH_COLON);
					add_ws();
				end
				filled[lvl]++;
				if (lvl + 1 < depth_cap && $urandom_range(0, 2) == 0) begin
					lvl++;
					kinds[lvl]  = 1'($urandom_range(0, 1));
					filled[lvl] = 0;
					doc.push_back(opener(kinds[lvl]));
				end else begin
					add_scalar();
				end
			end
		end
		add_ws();
	endfunction

	// one random damage: overwrite, cut short, insert or append a mark
	function automatic void mangle();
		logic [7:0] marks [8] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA,
			CH_COLON, CH_QUOTE, CH_BSLASH};
		int pos;
		pos = $urandom_range(0, doc.size() - 1);
		case ($urandom_range(0, 3))
			0: doc[pos] = 8'($urandom_range(0, 255));
			1: while (doc.size() > pos + 1) void'(doc.pop_back());
			2: doc.insert(pos, marks[$urandom_range(0, 7)]);
			default: doc.push_back(marks[$urandom_range(0, 7)]);
		endcase
	endfunction

	function automatic void add_nest(input int levels);
		repeat (levels) doc.push_back(CH_LBRACK);
		repeat (levels) doc.push_back(CH_RBRACK);
	endfunction

	function automatic void build_random_doc();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 10)) doc.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 10) begin
			add_nest($urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 2));
		end else begin
			add_tree();
			if (pick >= 70) mangle();
			if (pick >= 95) mangle();
		end
	endfunction

	// drive one document, last flag on its final byte
	task automatic send_doc();
		int gap_odds;
		int i;
		gap_odds = $urandom_range(0, 2) * 4;
		for (i = 0; i < doc.size(); i++) begin
			if (gap_odds != 0 && bytes_sent < CALM_AFTER && $urandom_range(1, gap_odds) == 1) begin
				text_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			text_ch.valid     <= 1'b1;
			text_ch.data_byte <= doc[i];
			text_ch.last_byte <= (i == doc.size() - 1);
			do @(posedge clk); while (!text_ch.ready);
			bytes_sent++;
		end
		docs_sent++;
		doc.delete();
	endtask

	// verdict side: random stalls, quiet stretches, one long hold-off
	initial begin
		status_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
			if (arst_n && !long_hold_done && bytes_sent >= HOLD_AT) begin
				long_hold_done = 1'b1;
				status_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				status_ch.ready <= 1'b1;
			end else if (stall_mode && bytes_sent < CALM_AFTER && $urandom_range(0, 5) == 0) begin
				status_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				status_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (status_ch.valid && status_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int k;
		arst_n            <= 1'b0;
		text_ch.valid     <= 1'b0;
		text_ch.data_byte <= 8'h00;
		text_ch.last_byte <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked documents and a single out-of-range byte
		for (k = 0; k < 6; k++) begin
			load_text(directed_docs[k]);
			send_doc();
		end
		doc.push_back(8'hFF);
		send_doc();

		// nesting exactly at the limit, then one level past it
		add_nest(MAX_DEPTH);
		send_doc();
		add_nest(MAX_DEPTH + 1);
		send_doc();

		// random documents
		while (bytes_sent < ITEM_TARGET) begin
			build_random_doc();
			send_doc();
		end
		text_ch.valid <= 1'b0;

		// let the last verdicts drain
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d documents, %0d bytes, %0d verdicts compared",
			docs_sent, bytes_sent, verdicts_seen);
		$display("documents predicted accepted %0d, rejected %0d", docs_ok, docs_bad);
		if (fail_count == 0 && open_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/jsv_pkg.sv
sv/jsv_text_if.sv
sv/jsv_status_if.sv
sv/jsv_ram.sv
sv/json_syntax_validator_core.sv
tb/jsv_verdict_checker.sv
tb/tb_json_syntax_validator_core.sv
